[sv/rpot_pkg.sv]
// ----------------------------------------------------------------------------
// rpot_pkg: shared types, constants and functions of the pose tracker
// Beat payloads, trig pair type, fixed-point constants, saturation helper
// and the quarter-wave sine entry generator used at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package rpot_pkg;

  // Default size of the trig circle, in index bits
  localparam int TRIG_BITS_DEF = 10;

  // Heading constants in Q3.13
  localparam int YAW_PI     = 25736;
  localparam int YAW_TWO_PI = 51472;

  // Sine entries in Q1.14, unsigned magnitude
  localparam int ROM_W   = 15;
  localparam int ONE_Q14 = 16384;

  // 2*pi in Q30, for building the sine table
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // Action codes
  localparam logic ACT_SAMPLE      = 1'b0;
  localparam logic ACT_MOVE_ORIGIN = 1'b1;

  // Saturation bounds for 32-bit signed results
  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  typedef struct packed {
    logic              action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] yaw;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] turned;
    logic              ready_res;
  } out_item_t;

  // Cosine and sine of the origin heading, Q1.14
  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } trig_t;

  // Clamp a wide signed value into 32 bits
  function automatic logic signed [31:0] sat_s32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // One quarter-wave entry: sin(2*pi*q/2^bits) by Taylor series in Q30,
  // rounded half up to Q1.14 and capped at one
  function automatic logic [ROM_W-1:0] rom_entry(input int unsigned q,
                                                 input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    int                 k;
    x    = (64'(q) * TWO_PI_Q30) >> bits;
    term = x;
    sum  = $signed(x);
    for (k = 1; k <= 5; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      unique case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        default: term = term / 64'd110;
      endcase
      if ((k % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) * 64'(ONE_Q14) + (64'd1 << 29)) >> 30;
    if (r > 64'(ONE_Q14)) begin
      r = 64'(ONE_Q14);
    end
    return r[ROM_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/rpot_trig.sv]
// ----------------------------------------------------------------------------
// rpot_trig: heading to cosine/sine lookup
// Reduces a Q3.13 heading modulo 2*pi, rounds it onto a circle of
// 2^TRIG_TABLE_BITS steps and reads both values from a quarter-wave table.
// ----------------------------------------------------------------------------
`default_nettype none

module rpot_trig #(
  parameter int TRIG_TABLE_BITS = rpot_pkg::TRIG_BITS_DEF
) (
  input  wire logic signed [15:0] heading,
  output rpot_pkg::trig_t         trig
);
  import rpot_pkg::*;

  localparam int B  = TRIG_TABLE_BITS;
  localparam int N  = 1 << B;
  localparam int QS = N / 4;
  // Scaled angle width, shift and reciprocal for the divide by 2*pi.
  // 2*pi = 16 * 3217: drop four bits, then multiply by ceil(2^SH / 3217).
  localparam int VW   = 16 + B;
  localparam int DIV3 = YAW_TWO_PI / 16;
  localparam int SH   = VW + 8;
  localparam int MW   = SH - 11;
  localparam int PW   = (VW - 4) + MW;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIV3) - 64'd1) / 64'(DIV3);

  localparam logic [B:0] Q1 = (B+1)'(QS);
  localparam logic [B:0] Q2 = (B+1)'(2 * QS);
  localparam logic [B:0] Q3 = (B+1)'(3 * QS);
  localparam logic [B:0] Q4 = (B+1)'(N);

  logic [ROM_W-1:0] rom [QS+1];

  logic [16:0]   wrap17;
  logic [15:0]   ang_u;
  logic [VW-1:0] ang_scaled;
  logic [PW-1:0] quot;
  logic [B-1:0]  sin_idx;
  logic [B-1:0]  cos_idx;
  logic [B-1:0]  sin_fold;
  logic [B-1:0]  cos_fold;
  logic [ROM_W-1:0] sin_mag;
  logic [ROM_W-1:0] cos_mag;

  // Build the quarter-wave table as constants
  for (genvar g = 0; g <= QS; g++) begin : g_rom
    assign rom[g] = rom_entry(g, B);
  end

  // Map a circle index onto the quarter wave: {negate, table index}
  function automatic logic [B-1:0] fold(input logic [B-1:0] i);
    logic [B:0] w;
    logic [B:0] t;
    logic       neg;
    w = {1'b0, i};
    priority if (w <= Q1) begin
      t   = w;
      neg = 1'b0;
    end else if (w <= Q2) begin
      t   = Q2 - w;
      neg = 1'b0;
    end else if (w <= Q3) begin
      t   = w - Q2;
      neg = 1'b1;
    end else begin
      t   = Q4 - w;
      neg = 1'b1;
    end
    return {neg, t[B-2:0]};
  endfunction

  // Reduce into [0, 2*pi), scale and round to the nearest step
  always_comb begin
    wrap17     = 17'(heading) + (heading[15] ? 17'(YAW_TWO_PI) : 17'd0);
    ang_u      = wrap17[15:0];
    ang_scaled = {ang_u, {B{1'b0}}} + VW'(YAW_PI);
    quot       = PW'(ang_scaled[VW-1:4]) * PW'(RECIP);
    sin_idx    = quot[SH +: B];
    cos_idx    = sin_idx + B'(QS);
  end

  // Read both values and apply the quadrant sign
  always_comb begin
    sin_fold   = fold(sin_idx);
    cos_fold   = fold(cos_idx);
    sin_mag    = rom[sin_fold[B-2:0]];
    cos_mag    = rom[cos_fold[B-2:0]];
    trig.sin_v = sin_fold[B-1] ? -16'(sin_mag) : 16'(sin_mag);
    trig.cos_v = cos_fold[B-1] ? -16'(cos_mag) : 16'(cos_mag);
  end

endmodule

`default_nettype wire

[sv/rpot_rotate.sv]
// ----------------------------------------------------------------------------
// rpot_rotate: rotate a displacement into the origin heading frame
// Forms dx/dy from the origin, multiplies by cosine and sine, rounds the
// Q14 fraction half up and saturates to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rpot_rotate (
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  input  wire rpot_pkg::trig_t    trig,
  output logic signed [31:0]      rel_x,
  output logic signed [31:0]      rel_y
);
  import rpot_pkg::*;

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [48:0] p_xc;
  logic signed [48:0] p_ys;
  logic signed [48:0] p_yc;
  logic signed [48:0] p_xs;
  logic signed [49:0] acc_x;
  logic signed [49:0] acc_y;

  // Displacement and the four products
  always_comb begin
    dx   = 33'(pos_x) - 33'(origin_x);
    dy   = 33'(pos_y) - 33'(origin_y);
    p_xc = 49'(dx) * 49'(trig.cos_v);
    p_ys = 49'(dy) * 49'(trig.sin_v);
    p_yc = 49'(dy) * 49'(trig.cos_v);
    p_xs = 49'(dx) * 49'(trig.sin_v);
  end

  // Sum, round half up by 2^14, clamp
  always_comb begin
    acc_x = 50'(p_xc) + 50'(p_ys) + 50'sd8192;
    acc_y = 50'(p_yc) - 50'(p_xs) + 50'sd8192;
    rel_x = sat_s32(acc_x >>> 14);
    rel_y = sat_s32(acc_y >>> 14);
  end

endmodule

`default_nettype wire

[sv/relative_pose_odometry_tracker.sv]
// ----------------------------------------------------------------------------
// relative_pose_odometry_tracker: planar pose relative to a movable origin
// Takes pose samples and move-origin commands, returns one result beat each.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_stall/in_data) carry an action bit, x/y in
//   Q16.16 and yaw in Q3.13. Action 0 is a pose sample, action 1 moves the
//   origin to the last sample. Every input beat yields exactly one result
//   beat on out_valid/out_stall/out_data: rel_x/rel_y rotated into the
//   origin heading frame, the unwrapped heading change and a ready flag.
//   out_valid rises once the beat has passed the input register into the
//   result register; one beat per cycle is sustained while out_stall is
//   low. One pass of subtract, multiply, round and saturate fills the result
//   register, while the origin trig lookup refreshes for the next item.
//   When the receiver stalls, the result register holds and the input
//   register takes one more beat before in_stall rises.
//   Synchronous reset clears all tracking state: no origin taken, unit
//   cosine, zero sine, zero heading sum.
// ----------------------------------------------------------------------------
`default_nettype none

module relative_pose_odometry_tracker #(
  parameter int TRIG_TABLE_BITS = rpot_pkg::TRIG_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rpot_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rpot_pkg::out_item_t      out_data
);
  import rpot_pkg::*;

  localparam logic signed [17:0] PI_18     = 18'(YAW_PI);
  localparam logic signed [17:0] TWO_PI_18 = 18'(YAW_TWO_PI);

  // Input register
  logic     s0_valid_r, s0_valid_nxt;
  in_item_t s0_item_r,  s0_item_nxt;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r,  out_item_nxt;

  // Tracking state
  logic               seen_r,     seen_nxt;
  logic signed [31:0] last_x_r,   last_x_nxt;
  logic signed [31:0] last_y_r,   last_y_nxt;
  logic signed [31:0] origin_x_r, origin_x_nxt;
  logic signed [31:0] origin_y_r, origin_y_nxt;
  trig_t              trig_r,     trig_nxt;
  logic signed [15:0] prev_hd_r,  prev_hd_nxt;
  logic signed [31:0] hsum_r,     hsum_nxt;

  logic               res_ready;
  logic               in_acc;
  logic               adv;
  logic               is_move;
  logic signed [15:0] trig_angle;
  trig_t              trig_new;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [15:0] prev_eff;
  logic signed [31:0] hsum_eff;
  logic signed [17:0] diff_raw;
  logic signed [17:0] diff_wrap;
  logic signed [31:0] hsum_step;

  // Handshake: result slot frees when empty or being taken
  always_comb begin
    res_ready = !out_valid_r || !out_stall;
    adv       = s0_valid_r && res_ready;
    in_stall  = s0_valid_r && !res_ready;
    in_acc    = in_valid && !in_stall;
    out_valid = out_valid_r;
    out_data  = out_item_r;
  end

  // Trig of the heading that would become the origin heading
  always_comb begin
    is_move    = (s0_item_r.action == ACT_MOVE_ORIGIN);
    trig_angle = is_move ? prev_hd_r : s0_item_r.yaw;
  end

  rpot_trig #(
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
  ) u_trig (
    .heading (trig_angle),
    .trig    (trig_new)
  );

  rpot_rotate u_rotate (
    .pos_x    (s0_item_r.pos_x),
    .pos_y    (s0_item_r.pos_y),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .trig     (trig_r),
    .rel_x    (rot_x),
    .rel_y    (rot_y)
  );

  // Heading unwrap: wrap the step into (-pi, pi] and accumulate
  always_comb begin
    prev_eff  = seen_r ? prev_hd_r : s0_item_r.yaw;
    hsum_eff  = seen_r ? hsum_r : 32'sd0;
    diff_raw  = 18'(s0_item_r.yaw) - 18'(prev_eff);
    priority if (diff_raw > PI_18) begin
      diff_wrap = diff_raw - TWO_PI_18;
    end else if (diff_raw <= -PI_18) begin
      diff_wrap = diff_raw + TWO_PI_18;
    end else begin
      diff_wrap = diff_raw;
    end
    hsum_step = sat_s32(50'(hsum_eff) + 50'(diff_wrap));
  end

  // Next state and result for the item in the input register
  always_comb begin
    s0_valid_nxt  = s0_valid_r;
    s0_item_nxt   = s0_item_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    seen_nxt      = seen_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    origin_x_nxt  = origin_x_r;
    origin_y_nxt  = origin_y_r;
    trig_nxt      = trig_r;
    prev_hd_nxt   = prev_hd_r;
    hsum_nxt      = hsum_r;

    // Load or drain the input register
    if (in_acc) begin
      s0_valid_nxt = 1'b1;
      s0_item_nxt  = in_data;
    end else if (adv) begin
      s0_valid_nxt = 1'b0;
    end

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (adv) begin
      out_valid_nxt = 1'b1;
      if (is_move) begin
        // Move origin to the last sample; ignored before any sample
        if (seen_r) begin
          origin_x_nxt = last_x_r;
          origin_y_nxt = last_y_r;
          trig_nxt     = trig_new;
          hsum_nxt     = 32'sd0;
        end
        out_item_nxt.rel_x     = 32'sd0;
        out_item_nxt.rel_y     = 32'sd0;
        out_item_nxt.turned    = 32'sd0;
        out_item_nxt.ready_res = seen_r;
      end else begin
        // First sample becomes the origin and reports zero displacement
        if (!seen_r) begin
          seen_nxt     = 1'b1;
          origin_x_nxt = s0_item_r.pos_x;
          origin_y_nxt = s0_item_r.pos_y;
          trig_nxt     = trig_new;
        end
        last_x_nxt             = s0_item_r.pos_x;
        last_y_nxt             = s0_item_r.pos_y;
        prev_hd_nxt            = s0_item_r.yaw;
        hsum_nxt               = hsum_step;
        out_item_nxt.rel_x     = seen_r ? rot_x : 32'sd0;
        out_item_nxt.rel_y     = seen_r ? rot_y : 32'sd0;
        out_item_nxt.turned    = hsum_step;
        out_item_nxt.ready_res = 1'b1;
      end
    end
  end

  // Control and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      seen_r       <= 1'b0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      trig_r.cos_v <= 16'(ONE_Q14);
      trig_r.sin_v <= '0;
      prev_hd_r    <= '0;
      hsum_r       <= '0;
    end else begin
      s0_valid_r   <= s0_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      seen_r       <= seen_nxt;
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      origin_x_r   <= origin_x_nxt;
      origin_y_r   <= origin_y_nxt;
      trig_r       <= trig_nxt;
      prev_hd_r    <= prev_hd_nxt;
      hsum_r       <= hsum_nxt;
    end
  end

  // Beat payloads
  always_ff @(posedge clk) begin
    s0_item_r  <= s0_item_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for relative_pose_odometry_tracker
// Drives pose samples and move-origin commands through the valid/stall input
// channel, predicts each result beat in a scoreboard with its own sine table
// and tracking state, and compares every result beat field by field. Traffic
// runs in three random phases, including one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rpot_pkg::*;

  localparam int TRIG_BITS   = TRIG_BITS_DEF;
  localparam int CIRCLE      = 1 << TRIG_BITS;
  localparam int QUARTER     = CIRCLE / 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 10;
  localparam int HOLD_CYCLES = 64;
  localparam int MAX_REPORTS = 100;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the pose origin and heading sum, queues expected beats
  // --------------------------------------------------------------------------
  class pose_tracker_board;
    out_item_t owed_poses[$];
    int        errors;
    int        quarter_sine[QUARTER + 1];
    bit        took_first;
    int        last_x, last_y, org_x, org_y;
    int        org_cos, org_sin;
    int        prev_yaw;
    int        heading_sum;

    function new();
      longint unsigned x, term, r;
      longint          s;
      // Build the quarter-wave sine in Q1.14 from a Q30 Taylor series
      for (int q = 0; q <= QUARTER; q++) begin
        x    = (longint'(q) * TWO_PI_Q30) / CIRCLE;
        term = x;
        s    = x;
        for (int k = 1; k <= 5; k++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / ((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            s = s - term;
          end else begin
            s = s + term;
          end
        end
        if (s < 0) begin
          s = 0;
        end
        r = (longint'(s) * ONE_Q14 + 64'd536870912) >> 30;
        if (r > ONE_Q14) begin
          r = ONE_Q14;
        end
        quarter_sine[q] = int'(r);
      end
      errors      = 0;
      took_first  = 1'b0;
      last_x      = 0;
      last_y      = 0;
      org_x       = 0;
      org_y       = 0;
      org_cos     = ONE_Q14;
      org_sin     = 0;
      prev_yaw    = 0;
      heading_sum = 0;
    endfunction

    function int sine_at(int idx);
      int i;
      i = idx & (CIRCLE - 1);
      if (i <= QUARTER) return quarter_sine[i];
      if (i <= 2 * QUARTER) return quarter_sine[2 * QUARTER - i];
      if (i <= 3 * QUARTER) return -quarter_sine[i - 2 * QUARTER];
      return -quarter_sine[4 * QUARTER - i];
    endfunction

    // Reduce the heading modulo 2*pi, round to a circle index, look up trig
    function void aim_origin(int heading);
      int m, idx;
      m = heading % YAW_TWO_PI;
      if (m < 0) begin
        m += YAW_TWO_PI;
      end
      idx     = ((m * CIRCLE) + YAW_PI) / YAW_TWO_PI;
      idx     = idx & (CIRCLE - 1);
      org_sin = sine_at(idx);
      org_cos = sine_at(idx + QUARTER);
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
    endfunction

    // Round half toward +inf, dropping the Q14 trig fraction
    function longint round_q14(longint v);
      return (v + 64'sd8192) >>> 14;
    endfunction

    function out_item_t relative_pose(in_item_t it);
      out_item_t r;
      longint    px, py, dx, dy;
      int        yw, turn;
      r  = '0;
      px = $signed(it.pos_x);
      py = $signed(it.pos_y);
      yw = $signed(it.yaw);
      if (it.action == ACT_MOVE_ORIGIN) begin
        // Ignore the command until a first sample has set an origin
        if (took_first) begin
          org_x = last_x;
          org_y = last_y;
          aim_origin(prev_yaw);
          heading_sum = 0;
        end
      end else begin
        if (!took_first) begin
          took_first  = 1'b1;
          prev_yaw    = yw;
          org_x       = int'(px);
          org_y       = int'(py);
          aim_origin(yw);
          heading_sum = 0;
        end
        last_x   = int'(px);
        last_y   = int'(py);
        dx       = px - org_x;
        dy       = py - org_y;
        r.rel_x  = clamp32(round_q14(dx * org_cos + dy * org_sin));
        r.rel_y  = clamp32(round_q14(dy * org_cos - dx * org_sin));
        // Wrap the yaw step into (-pi, pi] and accumulate
        turn = yw - prev_yaw;
        while (turn > YAW_PI) turn -= YAW_TWO_PI;
        while (turn <= -YAW_PI) turn += YAW_TWO_PI;
        heading_sum = clamp32(longint'(heading_sum) + turn);
        prev_yaw    = yw;
        r.turned    = heading_sum;
      end
      r.ready_res = took_first;
      return r;
    endfunction

    function void note_input(in_item_t it);
      owed_poses.push_back(relative_pose(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_poses.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        end
        return;
      end
      want = owed_poses.pop_front();
      if (got.rel_x !== want.rel_x || got.rel_y !== want.rel_y ||
          got.turned !== want.turned || got.ready_res !== want.ready_res) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch expected x=%0d y=%0d turned=%0d ready=%0d",
                   $time, want.rel_x, want.rel_y, want.turned, want.ready_res);
          $display("%0t:            actual x=%0d y=%0d turned=%0d ready=%0d",
                   $time, got.rel_x, got.rel_y, got.turned, got.ready_res);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and shared knobs
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  pose_tracker_board board;
  int          send_gap_pct;
  int          recv_stall_pct;
  bit          hold_request;
  int unsigned cycle_count;
  int          traj_x, traj_y, traj_yaw;

  relative_pose_odometry_tracker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("relative_pose_odometry_tracker regression: fail");
      $finish;
    end
  end

  // Check every result beat taken at a rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int held;
    held      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        held         = HOLD_CYCLES;
      end
      if (held > 0) begin
        held--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t pose(logic act, int x, int y, int yw);
    in_item_t it;
    it.action = act;
    it.pos_x  = x;
    it.pos_y  = y;
    it.yaw    = yw[15:0];
    return it;
  endfunction

  // Mostly a smooth random walk, with some origin moves and raw noise
  function automatic in_item_t wander_item();
    int pick, reach;
    pick = $urandom_range(99);
    if (pick < 12) begin
      return pose(($urandom_range(1) == 1) ? ACT_MOVE_ORIGIN : ACT_SAMPLE,
                  $urandom, $urandom, $urandom);
    end
    if (pick < 22) begin
      return pose(ACT_MOVE_ORIGIN, $urandom, $urandom, $urandom);
    end
    reach    = ($urandom_range(19) == 0) ? (1 << 28) : (1 << 20);
    traj_x   = traj_x + $urandom_range(2 * reach) - reach;
    traj_y   = traj_y + $urandom_range(2 * reach) - reach;
    traj_yaw = traj_yaw + $urandom_range(6000) - 3000;
    if (traj_yaw > YAW_PI) traj_yaw -= YAW_TWO_PI;
    if (traj_yaw <= -YAW_PI) traj_yaw += YAW_TWO_PI;
    return pose(ACT_SAMPLE, traj_x, traj_y, traj_yaw);
  endfunction

  // Offer one beat, with random gaps first; return at the next falling edge
  task automatic push_pose(input in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    board.note_input(it);
    @(negedge clk);
  endtask

  task automatic run_phase(input int gap, input int stall, input int count,
                           input bit squeeze);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    if (squeeze) begin
      hold_request = 1'b1;
    end
    repeat (count) push_pose(wander_item());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    board          = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_gap_pct   = 31;
    recv_stall_pct = 71;
    hold_request   = 1'b0;
    cycle_count    = 0;
    traj_x         = 0;
    traj_y         = 0;
    traj_yaw       = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: move before first sample, extremes, yaw wrap edges
    push_pose(pose(ACT_MOVE_ORIGIN, 123, 456, 789));
    push_pose(pose(ACT_SAMPLE, 32'h8000_0000, 32'h7fff_ffff, YAW_PI));
    push_pose(pose(ACT_SAMPLE, 32'h7fff_ffff, 32'h8000_0000, -YAW_PI + 1));
    push_pose(pose(ACT_SAMPLE, 0, 0, -32768));
    push_pose(pose(ACT_SAMPLE, -1, -1, 32767));
    push_pose(pose(ACT_MOVE_ORIGIN, -1, 0, 0));
    push_pose(pose(ACT_SAMPLE, 32'h0001_0000, 32'h0002_0000, 0));
    push_pose(pose(ACT_SAMPLE, 65536, 65536, YAW_PI));
    push_pose(pose(ACT_SAMPLE, 0, 65536, 0));
    push_pose(pose(ACT_SAMPLE, 300000, -300000, -1));
    push_pose(pose(ACT_MOVE_ORIGIN, 32'hffff_ffff, 32'hffff_ffff, -1));
    push_pose(pose(ACT_SAMPLE, 12345678, -87654321, 12868));
    push_pose(pose(ACT_MOVE_ORIGIN, 0, 0, 0));
    push_pose(pose(ACT_SAMPLE, 32'h7fff_ffff, 32'h7fff_ffff, -12868));
    push_pose(pose(ACT_SAMPLE, 32'h8000_0000, 32'h8000_0000, 6434));
    push_pose(pose(ACT_MOVE_ORIGIN, 7, 7, 7));
    push_pose(pose(ACT_SAMPLE, 32'h5555_5555, 32'haaaa_aaaa, 16'h5555));
    push_pose(pose(ACT_SAMPLE, 32'haaaa_aaaa, 32'h5555_5555, -21846));
    push_pose(pose(ACT_SAMPLE, 0, 0, -YAW_PI));
    push_pose(pose(ACT_MOVE_ORIGIN, 1, 2, 3));
    push_pose(pose(ACT_MOVE_ORIGIN, 32'h8000_0000, 32'h7fff_ffff, -32768));

    // Random: sender-light, then receiver-light, then full rate with a squeeze
    run_phase(31, 71, 160, 1'b0);
    run_phase(71, 31, 160, 1'b0);
    run_phase(0, 0, 160, 1'b1);
    in_valid <= 1'b0;

    // Drain, then let any stray beat show up
    while (board.owed_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0 && board.owed_poses.size() == 0) begin
      $display("relative_pose_odometry_tracker regression: pass");
    end else begin
      $display("relative_pose_odometry_tracker regression: fail");
    end
    $finish;
  end

endmodule
